>>> src/ihyp_pkg.sv
// shared widths and the data record handed from one root cell to the next
// no dependencies
package ihyp_pkg;

    localparam int ROOT_BITS = 16;
    localparam int RAD_W     = 2 * ROOT_BITS;
    localparam int REM_W     = ROOT_BITS + 2;
    localparam int VALUE_W   = 32;
    localparam int LEG_W     = 16;
    localparam int OUT_W     = 16;

    // item kinds
    localparam logic KIND_SQRT  = 1'b0;
    localparam logic KIND_HYPOT = 1'b1;

    typedef logic [RAD_W-1:0]     rad_t;
    typedef logic [REM_W-1:0]     rem_t;
    typedef logic [ROOT_BITS-1:0] root_t;

    typedef struct packed {
        rem_t  rem;
        root_t root;
        rad_t  rad;
    } cell_data_t;

endpackage

>>> src/ihyp_front.sv
// front end: squares of the legs, then sum and radicand select
// depends on ihyp_pkg
module ihyp_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         up_valid,
    output logic                         up_ready,
    input  logic                         kind,
    input  logic [ihyp_pkg::VALUE_W-1:0] value,
    input  logic [ihyp_pkg::LEG_W-1:0]   dx,
    input  logic [ihyp_pkg::LEG_W-1:0]   dy,
    output logic                         dn_valid,
    input  logic                         dn_ready,
    output ihyp_pkg::rad_t               rad
);

    logic                           a_valid_reg, a_valid_next;
    logic                           a_kind_reg;
    logic [ihyp_pkg::VALUE_W-1:0]   a_value_reg;
    logic [2*ihyp_pkg::LEG_W-1:0]   a_sqx_reg, a_sqy_reg;
    logic                           b_valid_reg, b_valid_next;
    ihyp_pkg::rad_t                 b_rad_reg, b_rad_next;
    logic                           a_ready, b_ready;
    logic [ihyp_pkg::VALUE_W-1:0]   sum_w;

    assign b_ready  = !b_valid_reg || dn_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign up_ready = a_ready;
    assign dn_valid = b_valid_reg;
    assign rad      = b_rad_reg;

    // sum of squares wraps at the value width
    assign sum_w = ihyp_pkg::VALUE_W'(a_sqx_reg) + ihyp_pkg::VALUE_W'(a_sqy_reg);

    always_comb begin
        a_valid_next = a_valid_reg;
        if (a_ready) begin
            a_valid_next = up_valid;
        end
        b_valid_next = b_valid_reg;
        b_rad_next   = b_rad_reg;
        if (b_ready) begin
            b_valid_next = a_valid_reg;
            b_rad_next   = (a_kind_reg == ihyp_pkg::KIND_HYPOT) ? ihyp_pkg::rad_t'(sum_w)
                                                              : ihyp_pkg::rad_t'(a_value_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_ready) begin
            a_kind_reg  <= kind;
            a_value_reg <= value;
            a_sqx_reg   <= (2*ihyp_pkg::LEG_W)'(dx) * (2*ihyp_pkg::LEG_W)'(dx);
            a_sqy_reg   <= (2*ihyp_pkg::LEG_W)'(dy) * (2*ihyp_pkg::LEG_W)'(dy);
        end
        b_rad_reg <= b_rad_next;
    end

endmodule

>>> src/ihyp_cell.sv
// one restoring square-root step: brings down two radicand bits, decides one root bit
// depends on ihyp_pkg
module ihyp_cell (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 up_valid,
    output logic                 up_ready,
    input  ihyp_pkg::cell_data_t up_data,
    output logic                 dn_valid,
    input  logic                 dn_ready,
    output ihyp_pkg::cell_data_t dn_data
);

    logic                 valid_reg, valid_next;
    ihyp_pkg::cell_data_t data_reg, data_next;
    ihyp_pkg::rem_t       rem_sh, trial;
    ihyp_pkg::root_t      root_sh;
    logic                 fits;

    assign up_ready = !valid_reg || dn_ready;
    assign dn_valid = valid_reg;
    assign dn_data  = data_reg;

    always_comb begin
        rem_sh  = {up_data.rem[ihyp_pkg::REM_W-3:0],
                   up_data.rad[ihyp_pkg::RAD_W-1 -: 2]};
        root_sh = {up_data.root[ihyp_pkg::ROOT_BITS-2:0], 1'b0};
        trial   = ihyp_pkg::rem_t'({root_sh, 1'b1});
        fits    = (trial <= rem_sh);

        valid_next = valid_reg;
        data_next  = data_reg;
        if (up_ready) begin
            valid_next     = up_valid;
            data_next.rem  = fits ? (rem_sh - trial) : rem_sh;
            data_next.root = {root_sh[ihyp_pkg::ROOT_BITS-1:1], fits};
            data_next.rad  = {up_data.rad[ihyp_pkg::RAD_W-3:0], 2'b00};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

endmodule

>>> src/integer_sqrt_and_hypot_top.sv
// Integer square root and hypotenuse. Each item asks either for the floor square
// root of s_value (s_kind = 0) or for the floor root of s_dx*s_dx + s_dy*s_dy with
// the sum wrapped to 32 bits (s_kind = 1). The block is a pipeline that takes one
// item every cycle unless backpressure has filled it: two front stages form the
// squares and pick the radicand, then a row of 16 identical cells each settles one
// root bit, and each result is offered on m_valid from the last cell's register.
// Every stage holds its item under backpressure and empty stages keep filling, so
// up to 18 items are in flight and results come out in the order items went in.
// depends on ihyp_pkg, ihyp_front, ihyp_cell
module integer_sqrt_and_hypot_top (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_kind,
    input  logic [ihyp_pkg::VALUE_W-1:0] s_value,
    input  logic [ihyp_pkg::LEG_W-1:0]   s_dx,
    input  logic [ihyp_pkg::LEG_W-1:0]   s_dy,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [ihyp_pkg::OUT_W-1:0]   m_root
);

    logic                 front_valid, front_ready;
    ihyp_pkg::rad_t       front_rad;
    logic                 c_valid [ihyp_pkg::ROOT_BITS+1];
    logic                 c_ready [ihyp_pkg::ROOT_BITS+1];
    ihyp_pkg::cell_data_t c_data  [ihyp_pkg::ROOT_BITS+1];

    ihyp_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .up_valid (s_valid),
        .up_ready (s_ready),
        .kind     (s_kind),
        .value    (s_value),
        .dx       (s_dx),
        .dy       (s_dy),
        .dn_valid (front_valid),
        .dn_ready (front_ready),
        .rad      (front_rad)
    );

    // chain entry: empty remainder and root, full radicand
    assign c_valid[0]     = front_valid;
    assign front_ready    = c_ready[0];
    assign c_data[0].rem  = '0;
    assign c_data[0].root = '0;
    assign c_data[0].rad  = front_rad;

    for (genvar i = 0; i < ihyp_pkg::ROOT_BITS; i++) begin : g_cell
        ihyp_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .up_valid (c_valid[i]),
            .up_ready (c_ready[i]),
            .up_data  (c_data[i]),
            .dn_valid (c_valid[i+1]),
            .dn_ready (c_ready[i+1]),
            .dn_data  (c_data[i+1])
        );
    end

    assign m_valid = c_valid[ihyp_pkg::ROOT_BITS];
    assign c_ready[ihyp_pkg::ROOT_BITS] = m_ready;
    assign m_root  = ihyp_pkg::OUT_W'(c_data[ihyp_pkg::ROOT_BITS].root);

endmodule
